>>> rtl/fatd_pkg.sv
// ----------------------------------------------------------------------------
// fatd_pkg
// Shared types, constants and helpers of the flip-aware tile catalog.
// ----------------------------------------------------------------------------
`default_nettype none
package fatd_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int ROWS_PER_TILE   = 8;
	localparam int ROW_W           = 64;
	localparam int NUM_LANES       = 4;
	localparam int COUNT_W         = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam logic CMD_ROW   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [1:0] FLIP_NONE = 2'd0;
	localparam logic [1:0] FLIP_X    = 2'd1;
	localparam logic [1:0] FLIP_Y    = 2'd2;
	localparam logic [1:0] FLIP_XY   = 2'd3;

	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [NUM_LANES-1:0] lane_vec_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] flip;
	} merge_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_EVAL,
		ST_MISS,
		ST_STORE,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_PUB
	} state_t;

	// Reverse the order of the eight pixels of one row.
	function automatic row_t mirror_row(input row_t r);
		row_t o;
		for (int k = 0; k < 8; k++) begin
			o[k*8 +: 8] = r[(7-k)*8 +: 8];
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> rtl/fatd_tile_if.sv
// ----------------------------------------------------------------------------
// fatd_tile_if
// Input channel: one tile row or a clear command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface fatd_tile_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [63:0] row_pixels;

	modport source(output valid, cmd, row_pixels, input ready);
	modport sink(input valid, cmd, row_pixels, output ready);
endinterface
`default_nettype wire

>>> rtl/fatd_result_if.sv
// ----------------------------------------------------------------------------
// fatd_result_if
// Output channel: one lookup result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface fatd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  tile_id;
	logic [1:0]  flip;
	logic        was_new;
	logic        catalog_full;
	logic [31:0] use_count;

	modport source(output valid, tile_id, flip, was_new, catalog_full, use_count,
		input ready);
	modport sink(input valid, tile_id, flip, was_new, catalog_full, use_count,
		output ready);
endinterface
`default_nettype wire

>>> rtl/flip_aware_tile_dedup_catalog_core.sv
// Rows one to seven of a tile are only stored and give no result. After the
// eighth row each stored entry is searched in turn (eight reads of the tile
// memory port, then compare and evaluate); then the use count is updated for a
// match or the tile is stored as a new entry unless full, and the result is published.
// One tile is in work at a time; rows are accepted while a result waits.
// Reset empties the catalog and the row counter; memories are not cleared.
`default_nettype none
module flip_aware_tile_dedup_catalog_core #(
	parameter int MAX_ENTRIES = fatd_pkg::MAX_ENTRIES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	fatd_tile_if.sink    tile,
	fatd_result_if.source result
);
	import fatd_pkg::*;

	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = EW + 3;

	state_t state_q, state_d;

	row_t           rows_q [ROWS_PER_TILE];
	logic [2:0]     row_q;
	logic [CW-1:0]  entry_cnt_q;
	logic [EW-1:0]  ent_q;
	logic [2:0]     rd_row_q;
	logic [2:0]     wr_row_q;
	logic [1:0]     flip_q;

	row_t           tile_mem [2**AW];
	logic [COUNT_W-1:0] cnt_mem [2**EW];
	row_t           rdata_s1;
	logic [2:0]     row_s1;
	logic           valid_s1;
	logic [COUNT_W-1:0] cnt_rdata_q;

	logic           out_valid_q;
	logic [7:0]     id_q;
	logic [1:0]     oflip_q;
	logic           new_q;
	logic           full_q;
	logic [COUNT_W-1:0] ucount_q;

	// Result being assembled for publication.
	logic [7:0]     pid_q;
	logic [1:0]     pflip_q;
	logic           pnew_q;
	logic           pfull_q;
	logic [COUNT_W-1:0] pcount_q;

	lane_vec_t  flags;
	merge_res_t mres;
	row_t       inc_fwd, inc_rev;
	logic       accept, last_ent, is_full, pub_ok;
	logic [COUNT_W-1:0] cnt_next;
	logic [EW+7:0] ent_ext, new_ext;

	assign accept   = tile.valid & tile.ready;
	assign last_ent = ({{(CW-EW){1'b0}}, ent_q} + CW'(1)) == entry_cnt_q;
	assign is_full  = (entry_cnt_q == CW'(MAX_ENTRIES));
	assign pub_ok   = !out_valid_q || result.ready;
	assign cnt_next = (cnt_rdata_q == COUNT_MAX) ? cnt_rdata_q : cnt_rdata_q + 1'b1;
	assign ent_ext  = {8'd0, ent_q};
	assign new_ext  = {8'd0, entry_cnt_q[EW-1:0]};
	assign inc_fwd  = rows_q[row_s1];
	assign inc_rev  = rows_q[~row_s1];

	genvar g;
	generate
		for (g = 0; g < NUM_LANES; g++) begin : g_lane
			fatd_lane #(.MIRROR(g[0])) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (valid_s1),
				.first   (row_s1 == 3'd0),
				.stored  (rdata_s1),
				.incoming(g[1] ? inc_rev : inc_fwd),
				.match   (flags[g])
			);
		end
	endgenerate

	fatd_merge u_merge (
		.flags(flags),
		.res  (mres)
	);

	always_comb begin
		state_d     = state_q;
		tile.ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tile.ready = 1'b1;
				if (accept && tile.cmd == CMD_ROW && row_q == 3'd7) begin
					state_d = (entry_cnt_q == '0) ? ST_MISS : ST_SEARCH;
				end
			end
			ST_SEARCH: if (rd_row_q == 3'd7) state_d = ST_CHECK;
			ST_CHECK:  state_d = ST_EVAL;
			ST_EVAL: begin
				if (mres.hit) begin
					state_d = ST_CNT_RD;
				end else if (last_ent) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_MISS:   state_d = is_full ? ST_PUB : ST_STORE;
			ST_STORE:  if (wr_row_q == 3'd7) state_d = ST_PUB;
			ST_CNT_RD: state_d = ST_CNT_WR;
			ST_CNT_WR: state_d = ST_PUB;
			ST_PUB:    if (pub_ok) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			entry_cnt_q <= '0;
			ent_q       <= '0;
			rd_row_q    <= '0;
			wr_row_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			valid_s1    <= (state_q == ST_SEARCH);
			out_valid_q <= (state_q == ST_PUB && pub_ok) || (out_valid_q && !result.ready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tile.cmd == CMD_CLEAR) begin
							entry_cnt_q <= '0;
							row_q       <= '0;
						end else begin
							row_q    <= row_q + 3'd1;
							ent_q    <= '0;
							rd_row_q <= '0;
							wr_row_q <= '0;
						end
					end
				end
				ST_SEARCH: rd_row_q <= rd_row_q + 3'd1;
				ST_EVAL: if (!mres.hit) ent_q <= ent_q + 1'b1;
				ST_STORE: begin
					wr_row_q <= wr_row_q + 3'd1;
					if (wr_row_q == 3'd7) entry_cnt_q <= entry_cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept && tile.cmd == CMD_ROW) rows_q[row_q] <= tile.row_pixels;
		rdata_s1 <= tile_mem[{ent_q, rd_row_q}];
		row_s1   <= rd_row_q;
		if (state_q == ST_STORE) begin
			tile_mem[{entry_cnt_q[EW-1:0], wr_row_q}] <= rows_q[wr_row_q];
		end
		if (state_q == ST_EVAL) flip_q <= mres.flip;
		if (state_q == ST_CNT_RD) cnt_rdata_q <= cnt_mem[ent_q];
		if (state_q == ST_CNT_WR) cnt_mem[ent_q] <= cnt_next;
		if (state_q == ST_STORE && wr_row_q == 3'd7) cnt_mem[entry_cnt_q[EW-1:0]] <= 32'd1;
		case (state_q)
			ST_MISS: begin
				pid_q    <= is_full ? 8'd0 : new_ext[7:0];
				pflip_q  <= FLIP_NONE;
				pnew_q   <= !is_full;
				pfull_q  <= is_full;
				pcount_q <= is_full ? 32'd0 : 32'd1;
			end
			ST_CNT_WR: begin
				pid_q    <= ent_ext[7:0];
				pflip_q  <= flip_q;
				pnew_q   <= 1'b0;
				pfull_q  <= 1'b0;
				pcount_q <= cnt_next;
			end
			default: ;
		endcase
		if (state_q == ST_PUB && pub_ok) begin
			id_q     <= pid_q;
			oflip_q  <= pflip_q;
			new_q    <= pnew_q;
			full_q   <= pfull_q;
			ucount_q <= pcount_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.tile_id      = id_q;
	assign result.flip         = oflip_q;
	assign result.was_new      = new_q;
	assign result.catalog_full = full_q;
	assign result.use_count    = ucount_q;
endmodule
`default_nettype wire

>>> rtl/fatd_lane.sv
// ----------------------------------------------------------------------------
// fatd_lane
// One compare lane: tracks whether a stored entry, under one flip, equals the
// incoming tile, one row per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module fatd_lane #(
	parameter bit MIRROR = 1'b0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire              first,
	input  wire fatd_pkg::row_t stored,
	input  wire fatd_pkg::row_t incoming,
	output logic             match
);
	import fatd_pkg::*;

	row_t cand;
	logic eq;
	logic match_q;

	assign cand  = MIRROR ? mirror_row(stored) : stored;
	assign eq    = (cand == incoming);
	assign match = match_q;

	// The first row restarts the running AND for a new entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (en) begin
			match_q <= (first ? 1'b1 : match_q) & eq;
		end
	end
endmodule
`default_nettype wire

>>> rtl/fatd_merge.sv
// ----------------------------------------------------------------------------
// fatd_merge
// Combines the lane flags: the lowest flip code that matched wins.
// ----------------------------------------------------------------------------
`default_nettype none
module fatd_merge (
	input  wire fatd_pkg::lane_vec_t  flags,
	output fatd_pkg::merge_res_t      res
);
	import fatd_pkg::*;

	always_comb begin
		res.hit  = |flags;
		res.flip = FLIP_NONE;
		if (flags[0]) begin
			res.flip = FLIP_NONE;
		end else if (flags[1]) begin
			res.flip = FLIP_X;
		end else if (flags[2]) begin
			res.flip = FLIP_Y;
		end else if (flags[3]) begin
			res.flip = FLIP_XY;
		end
	end
endmodule
`default_nettype wire

>>> rtl/fatd_checker.sv
// ----------------------------------------------------------------------------
// fatd_checker
// Port-level checks of the tile catalog results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fatd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        valid,
	input wire        ready,
	input wire [7:0]  tile_id,
	input wire [1:0]  flip,
	input wire        was_new,
	input wire        catalog_full,
	input wire [31:0] use_count
);
	// A pending transaction stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result dropped before it was taken");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid && catalog_full |-> tile_id == 8'd0 && flip == 2'd0 && !was_new
			&& use_count == 32'd0)
		else $error("full result carries data");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		valid && was_new |-> flip == 2'd0 && use_count == 32'd1)
		else $error("new entry with wrong flip or count");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !catalog_full |-> use_count != 32'd0)
		else $error("stored entry with zero use count");
endmodule

bind flip_aware_tile_dedup_catalog_core fatd_checker u_fatd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.tile_id     (result.tile_id),
	.flip        (result.flip),
	.was_new     (result.was_new),
	.catalog_full(result.catalog_full),
	.use_count   (result.use_count)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flip-aware tile catalog. Tiles are sent one row
// per transaction with random gaps and output back-pressure. A scoreboard
// keeps its own copy of the catalog, predicts each lookup result and compares
// every result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import fatd_pkg::*;

	localparam int CATALOG_SIZE = MAX_ENTRIES_DEF;
	localparam int PHASE_ITEMS  = 96;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = 10 * CATALOG_SIZE + 13;

	typedef row_t tile_rows_t [ROWS_PER_TILE];

	typedef struct packed {
		logic [7:0]         tile_id;
		logic [1:0]         flip;
		logic               was_new;
		logic               catalog_full;
		logic [COUNT_W-1:0] use_count;
	} lookup_t;

	class catalog_scoreboard;
		row_t        stored [CATALOG_SIZE][ROWS_PER_TILE];
		int unsigned uses [CATALOG_SIZE];
		int          entries;
		int          next_row;
		row_t        gathering [ROWS_PER_TILE];
		lookup_t     awaited [$];
		int          errors;

		function new();
			entries  = 0;
			next_row = 0;
			errors   = 0;
		endfunction

		function row_t reverse_pixels(row_t r);
			row_t o;
			for (int k = 0; k < 8; k++) o[8*k +: 8] = r[56 - 8*k +: 8];
			return o;
		endfunction

		function bit entry_equals(int e, logic [1:0] f);
			row_t r;
			for (int y = 0; y < ROWS_PER_TILE; y++) begin
				r = stored[e][f[1] ? ROWS_PER_TILE - 1 - y : y];
				if (f[0]) r = reverse_pixels(r);
				if (r != gathering[y]) return 0;
			end
			return 1;
		endfunction

		function void note_input(logic cmd, row_t px);
			lookup_t res;
			if (cmd == CMD_CLEAR) begin
				entries  = 0;
				next_row = 0;
				return;
			end
			gathering[next_row] = px;
			if (next_row != ROWS_PER_TILE - 1) begin
				next_row++;
				return;
			end
			next_row = 0;
			for (int e = 0; e < entries; e++) begin
				for (int f = 0; f < 4; f++) begin
					if (entry_equals(e, f[1:0])) begin
						if (uses[e] != COUNT_MAX) uses[e]++;
						res = '{tile_id: e[7:0], flip: f[1:0], was_new: 1'b0,
							catalog_full: 1'b0, use_count: uses[e]};
						awaited.push_back(res);
						return;
					end
				end
			end
			if (entries >= CATALOG_SIZE) begin
				res = '{tile_id: 8'd0, flip: FLIP_NONE, was_new: 1'b0,
					catalog_full: 1'b1, use_count: '0};
			end else begin
				for (int y = 0; y < ROWS_PER_TILE; y++) stored[entries][y] = gathering[y];
				uses[entries] = 1;
				res = '{tile_id: entries[7:0], flip: FLIP_NONE, was_new: 1'b1,
					catalog_full: 1'b0, use_count: 32'd1};
				entries++;
			end
			awaited.push_back(res);
		endfunction

		function void check_result(lookup_t got);
			lookup_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction: %p", got);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("result mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fatd_tile_if   tile();
	fatd_result_if result();

	flip_aware_tile_dedup_catalog_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tile(tile.sink),
		.result(result.source)
	);

	catalog_scoreboard catalog = new();

	int          send_idle = 30;
	int          recv_idle = 49;
	int          hold_left = 0;
	int          items_sent = 0;
	longint      cycles = 0;

	always #4 clk = ~clk;

	initial begin
		tile.valid      = 1'b0;
		tile.cmd        = CMD_ROW;
		tile.row_pixels = '0;
		result.ready    = 1'b0;
	end

	// Output side: ready is chosen at the falling edge, results are taken at the rising edge.
	always @(negedge clk) begin
		result.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_left > 0) hold_left <= hold_left - 1;
		if (arst_n && result.valid && result.ready)
			catalog.check_result('{tile_id: result.tile_id, flip: result.flip,
				was_new: result.was_new, catalog_full: result.catalog_full,
				use_count: result.use_count});
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Called and returning at a falling edge; valid stays high between back-to-back items.
	task automatic send_item(logic cmd, row_t px);
		while ($urandom_range(99) < send_idle) begin
			tile.valid <= 1'b0;
			@(negedge clk);
		end
		tile.valid      <= 1'b1;
		tile.cmd        <= cmd;
		tile.row_pixels <= px;
		forever begin
			@(posedge clk);
			if (tile.ready) break;
			@(negedge clk);
		end
		catalog.note_input(cmd, px);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_tile(tile_rows_t t);
		for (int y = 0; y < ROWS_PER_TILE; y++) send_item(CMD_ROW, t[y]);
	endtask

	function automatic row_t random_row();
		return {$urandom, $urandom};
	endfunction

	function automatic tile_rows_t random_tile();
		tile_rows_t t;
		for (int y = 0; y < ROWS_PER_TILE; y++) t[y] = random_row();
		return t;
	endfunction

	// Few pixel values make accidental symmetries and partial row matches likely.
	function automatic tile_rows_t sparse_tile();
		tile_rows_t t;
		for (int y = 0; y < ROWS_PER_TILE; y++)
			for (int k = 0; k < 8; k++) t[y][8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
		return t;
	endfunction

	function automatic tile_rows_t mirror_tile(tile_rows_t t, logic [1:0] f);
		tile_rows_t o;
		for (int y = 0; y < ROWS_PER_TILE; y++) begin
			o[y] = t[f[1] ? ROWS_PER_TILE - 1 - y : y];
			if (f[0]) o[y] = catalog.reverse_pixels(o[y]);
		end
		return o;
	endfunction

	// Rows symmetric in X, and the row order symmetric in Y when asked.
	function automatic tile_rows_t symmetric_tile(bit also_y);
		tile_rows_t t;
		for (int y = 0; y < ROWS_PER_TILE; y++) begin
			t[y] = random_row();
			for (int k = 0; k < 4; k++) t[y][56 - 8*k +: 8] = t[y][8*k +: 8];
		end
		if (also_y) for (int y = 0; y < 4; y++) t[ROWS_PER_TILE - 1 - y] = t[y];
		return t;
	endfunction

	function automatic tile_rows_t stored_tile(int e);
		tile_rows_t t;
		for (int y = 0; y < ROWS_PER_TILE; y++) t[y] = catalog.stored[e][y];
		return t;
	endfunction

	task automatic random_phase(int stop_at);
		int pick;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (catalog.entries > 40 || pick < 6) begin
				send_item(CMD_CLEAR, random_row());
			end else if (pick < 12) begin
				repeat ($urandom_range(1, ROWS_PER_TILE - 1)) send_item(CMD_ROW, random_row());
				send_item(CMD_CLEAR, random_row());
			end else if (pick < 60 && catalog.entries > 0) begin
				send_tile(mirror_tile(stored_tile($urandom_range(catalog.entries - 1)),
					2'($urandom_range(3))));
			end else if (pick < 72) begin
				send_tile(symmetric_tile(1'($urandom_range(1))));
			end else if (pick < 82) begin
				send_tile(sparse_tile());
			end else begin
				send_tile(random_tile());
			end
		end
	endtask

	initial begin
		tile_rows_t t;
		tile_rows_t a;
		int         wait_cycles;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every flip code, a clear in the middle of a tile.
		for (int y = 0; y < ROWS_PER_TILE; y++) t[y] = '0;
		send_tile(t);
		send_tile(t);
		for (int y = 0; y < ROWS_PER_TILE; y++) t[y] = '1;
		send_tile(t);
		a = random_tile();
		send_tile(a);
		send_tile(mirror_tile(a, FLIP_X));
		send_tile(mirror_tile(a, FLIP_Y));
		send_tile(mirror_tile(a, FLIP_XY));
		send_tile(a);
		repeat (3) send_item(CMD_ROW, random_row());
		send_item(CMD_CLEAR, '1);
		send_tile(a);
		send_item(CMD_CLEAR, '0);

		// Fill the catalog, then look up tiles with no room left.
		for (int n = 0; n < CATALOG_SIZE; n++) send_tile(random_tile());
		send_tile(random_tile());
		send_tile(random_tile());
		send_tile(mirror_tile(stored_tile(CATALOG_SIZE - 1), FLIP_XY));
		send_tile(mirror_tile(stored_tile(0), FLIP_Y));
		send_item(CMD_CLEAR, random_row());

		send_idle = 49;
		recv_idle = 30;
		hold_left = 600;
		random_phase(items_sent + PHASE_ITEMS);

		send_idle = 0;
		recv_idle = 0;
		random_phase(items_sent + PHASE_ITEMS);
		tile.valid <= 1'b0;

		while (catalog.awaited.size() != 0) @(posedge clk);
		wait_cycles = DRAIN_CYCLES;
		repeat (wait_cycles) @(posedge clk);

		if (catalog.errors == 0 && catalog.awaited.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
